@@ sv/sorted_priority_queue_remove_by_id_top_assert.svh @@
// Assertion macros for the sorted priority queue RTL.
// Included by modules that check their own logic; needs no other file.
`ifndef SORTED_PRIORITY_QUEUE_REMOVE_BY_ID_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_REMOVE_BY_ID_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, off while reset is high.
`define SPQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPQ_ASSERT(lbl, clk, rst, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ sv/spq_pkg.sv @@
// Shared types and constants of the sorted priority queue.
// No dependencies; used by spq_cell, spq_chain and the top level.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam int KEY_W         = 14;
   localparam int ID_W          = 32;
   localparam int COUNT_OUT_W   = 5;
   localparam int DEPTH_DEFAULT = 16;
   localparam logic [KEY_W-1:0] KEY_MAX = 14'd10000;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_POP    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_NOTFOUND = 2'd2,
      STAT_FULL     = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE  = 1'b0,
      S_SWEEP = 1'b1
   } state_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_ROTATE
   } cell_op_type;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [ID_W-1:0]  id;
   } entry_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      cell_op_type      op;
      logic [KEY_W-1:0] key;   // insert key, already saturated
      logic [ID_W-1:0]  id;    // insert id
      logic             drop;  // rotate: head entry leaves the queue
   } chain_ctl_type;

endpackage

`default_nettype wire

@@ sv/spq_cell.sv @@
// One slot of the sorted chain: holds an entry, shifts with its neighbors.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire spq_pkg::chain_ctl_type ctl,
   input  wire spq_pkg::entry_type    head,     // entry of slot 0
   input  wire spq_pkg::entry_type    left,     // neighbor nearer the head
   input  wire logic                  left_ge,  // left holds key >= ctl.key
   input  wire spq_pkg::entry_type    right,    // neighbor nearer the tail
   output spq_pkg::entry_type         entry,
   output logic                       ge
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   assign entry = entry_ff;
   assign ge    = entry_ff.valid && (entry_ff.key >= ctl.key);

   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.op)
         spq_pkg::OP_HOLD: begin
            entry_in = entry_ff;
         end
         spq_pkg::OP_INSERT: begin
            // higher-or-equal prefix stays; the first slot past it takes
            // the new item, the rest take their left neighbor
            priority if (ge) begin
               entry_in = entry_ff;
            end else if (left_ge) begin
               entry_in.valid = 1'b1;
               entry_in.key   = ctl.key;
               entry_in.id    = ctl.id;
            end else begin
               entry_in = left;
            end
         end
         spq_pkg::OP_ROTATE: begin
            // shift toward the head; the tail slot takes the old head back
            priority if (right.valid) begin
               entry_in = right;
            end else if (entry_ff.valid) begin
               entry_in       = head;
               entry_in.valid = !ctl.drop;
            end else begin
               entry_in = entry_ff;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.key <= entry_in.key;
      entry_ff.id  <= entry_in.id;
   end

endmodule

`default_nettype wire

@@ sv/spq_chain.sv @@
// Row of DEPTH spq_cell slots, sorted highest key first, packed from slot 0.
// Depends on spq_pkg and spq_cell.
`timescale 1ns / 1ps
`default_nettype none

module spq_chain #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire spq_pkg::chain_ctl_type ctl,
   output spq_pkg::entry_type          head
);

   spq_pkg::entry_type ent [DEPTH];
   logic [DEPTH-1:0]   ge;

   assign head = ent[0];

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      spq_pkg::entry_type left_e;
      spq_pkg::entry_type right_e;
      logic               left_ge;

      if (g == 0) begin : g_first
         assign left_e  = '0;
         assign left_ge = 1'b1;
      end else begin : g_mid
         assign left_e  = ent[g-1];
         assign left_ge = ge[g-1];
      end

      if (g == DEPTH-1) begin : g_last
         assign right_e = '0;
      end else begin : g_inner
         assign right_e = ent[g+1];
      end

      spq_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .head    (ent[0]),
         .left    (left_e),
         .left_ge (left_ge),
         .right   (right_e),
         .entry   (ent[g]),
         .ge      (ge[g])
      );
   end

endmodule

`default_nettype wire

@@ sv/sorted_priority_queue_remove_by_id_top.sv @@
// Sorted priority queue with remove-by-id: command control and result port.
// Depends on spq_pkg, spq_chain, spq_cell and the assertion header.
//
// Bounded queue of DEPTH entries (key, id), kept highest key first in a
// chain of slot cells; equal keys leave in arrival order. An item is taken
// when start is high and busy is low. For insert, pop and the unused
// command busy stays low and the result strobes on rsp_strobe the next
// cycle, so a new item may follow every cycle. Remove-by-id rotates the
// chain once through the head comparator, one slot per cycle: busy is high
// during the rotation and the result strobes in the cycle after the last
// step; a remove on an empty queue answers in the next cycle. The
// receiver cannot stall: each result is on the rsp_ ports for exactly one
// cycle, marked by rsp_strobe. Keys above 10000 are saturated to 10000.
// Reset clears the queue.
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_priority_queue_remove_by_id_top_assert.svh"

module sorted_priority_queue_remove_by_id_top #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [1:0]                        req_command,
   input  wire logic [spq_pkg::KEY_W-1:0]         req_key,
   input  wire logic [spq_pkg::ID_W-1:0]          req_id,
   output logic                                   rsp_strobe,
   output logic [1:0]                             rsp_status,
   output logic [spq_pkg::KEY_W-1:0]              rsp_out_key,
   output logic [spq_pkg::ID_W-1:0]               rsp_out_id,
   output logic [spq_pkg::COUNT_OUT_W-1:0]        rsp_entry_count
);

   localparam int CW = $clog2(DEPTH + 1);

   // control state
   spq_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      steps_ff, steps_in;   // rotation steps left in a remove
   logic               found_ff, found_in;
   logic               rsp_strobe_ff, rsp_strobe_in;

   // payload
   logic [spq_pkg::ID_W-1:0]  tgt_ff, tgt_in;
   logic [spq_pkg::KEY_W-1:0] cap_key_ff, cap_key_in;
   logic [spq_pkg::ID_W-1:0]  cap_id_ff, cap_id_in;
   spq_pkg::status_type       rsp_status_ff, rsp_status_in;
   logic [spq_pkg::KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic [spq_pkg::ID_W-1:0]  rsp_id_ff, rsp_id_in;
   logic [CW-1:0]             rsp_cnt_ff;

   spq_pkg::chain_ctl_type    ctl;
   spq_pkg::entry_type        head;
   spq_pkg::cmd_type          cmd;
   logic                      accept;
   logic                      hit;
   logic [spq_pkg::KEY_W-1:0] key_sat;
   logic [CW+spq_pkg::COUNT_OUT_W-1:0] cnt_ext;

   assign busy    = (state_ff == spq_pkg::S_SWEEP);
   assign accept  = start && !busy;
   assign cmd     = spq_pkg::cmd_type'(req_command);
   assign key_sat = (req_key > spq_pkg::KEY_MAX) ? spq_pkg::KEY_MAX : req_key;
   // first matching entry, in priority order, as it passes the head
   assign hit     = head.valid && (head.id == tgt_ff) && !found_ff;

   spq_chain #(
      .DEPTH (DEPTH)
   ) u_chain (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .head  (head)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spq_pkg::S_IDLE: begin
            if (accept && (cmd == spq_pkg::CMD_REMOVE) && (cnt_ff != '0)) begin
               state_in = spq_pkg::S_SWEEP;
            end
         end
         spq_pkg::S_SWEEP: begin
            if (steps_ff == CW'(1)) begin
               state_in = spq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = spq_pkg::S_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      ctl.op        = spq_pkg::OP_HOLD;
      ctl.key       = key_sat;
      ctl.id        = req_id;
      ctl.drop      = 1'b0;
      cnt_in        = cnt_ff;
      steps_in      = steps_ff;
      found_in      = found_ff;
      tgt_in        = tgt_ff;
      cap_key_in    = cap_key_ff;
      cap_id_in     = cap_id_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = spq_pkg::STAT_OK;
      rsp_key_in    = '0;
      rsp_id_in     = '0;

      unique case (state_ff)
         spq_pkg::S_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  spq_pkg::CMD_INSERT: begin
                     rsp_strobe_in = 1'b1;
                     if (cnt_ff == CW'(DEPTH)) begin
                        rsp_status_in = spq_pkg::STAT_FULL;
                     end else begin
                        ctl.op = spq_pkg::OP_INSERT;
                        cnt_in = cnt_ff + CW'(1);
                     end
                  end
                  spq_pkg::CMD_POP: begin
                     rsp_strobe_in = 1'b1;
                     if (cnt_ff == '0) begin
                        rsp_status_in = spq_pkg::STAT_EMPTY;
                     end else begin
                        ctl.op     = spq_pkg::OP_ROTATE;
                        ctl.drop   = 1'b1;
                        rsp_key_in = head.key;
                        rsp_id_in  = head.id;
                        cnt_in     = cnt_ff - CW'(1);
                     end
                  end
                  spq_pkg::CMD_REMOVE: begin
                     if (cnt_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = spq_pkg::STAT_EMPTY;
                     end else begin
                        steps_in = cnt_ff;
                        found_in = 1'b0;
                        tgt_in   = req_id;
                     end
                  end
                  spq_pkg::CMD_NONE: begin
                     rsp_strobe_in = 1'b1;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         spq_pkg::S_SWEEP: begin
            // rotate one slot; the matching head is dropped instead of wrapped
            ctl.op   = spq_pkg::OP_ROTATE;
            ctl.drop = hit;
            steps_in = steps_ff - CW'(1);
            if (hit) begin
               found_in   = 1'b1;
               cap_key_in = head.key;
               cap_id_in  = head.id;
               cnt_in     = cnt_ff - CW'(1);
            end
            if (steps_ff == CW'(1)) begin
               rsp_strobe_in = 1'b1;
               if (found_in) begin
                  rsp_status_in = spq_pkg::STAT_OK;
                  rsp_key_in    = cap_key_in;
                  rsp_id_in     = cap_id_in;
               end else begin
                  rsp_status_in = spq_pkg::STAT_NOTFOUND;
               end
            end
         end
         default: begin
            ctl.op = spq_pkg::OP_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= spq_pkg::S_IDLE;
         cnt_ff        <= '0;
         steps_ff      <= '0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         steps_ff      <= steps_in;
         found_ff      <= found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      tgt_ff        <= tgt_in;
      cap_key_ff    <= cap_key_in;
      cap_id_ff     <= cap_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_cnt_ff    <= cnt_in;
   end

   // count is reported modulo 32
   assign cnt_ext         = {{spq_pkg::COUNT_OUT_W{1'b0}}, rsp_cnt_ff};
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_id      = rsp_id_ff;
   assign rsp_entry_count = cnt_ext[spq_pkg::COUNT_OUT_W-1:0];

   `SPQ_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CW'(DEPTH), "entry count above depth")
   `SPQ_ASSERT(a_sweep_steps, clock, reset, busy |-> (steps_ff != '0), "sweep with no steps left")
   `SPQ_ASSERT(a_sweep_head, clock, reset, busy |-> head.valid, "sweep reached an empty head")
   `SPQ_ASSERT(a_quick_rsp, clock, reset, (accept && ((cmd != spq_pkg::CMD_REMOVE) || (cnt_ff == '0))) |=> rsp_strobe, "one-cycle command gave no result")
   `SPQ_ASSERT(a_empty_cnt, clock, reset, (rsp_strobe && (rsp_status == spq_pkg::STAT_EMPTY)) |-> (rsp_cnt_ff == '0), "empty status with entries held")

endmodule

`default_nettype wire
